// File: src/esmv_pkg.sv
// ----------------------------------------------------------------------------
// esmv_pkg
// shared sizes, codes and command types for the ellpack matrix-vector unit
// ----------------------------------------------------------------------------
package esmv_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int VECTOR_DEPTH = 1024;
    localparam int MAX_SLOTS    = 64;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int ACC_W   = 64;

    localparam int NUM_ROWS_W  = 11;
    localparam int NUM_SLOTS_W = 7;
    localparam int CFG_DW      = 11;
    localparam int CFG_IW      = 1;

    localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CW  = $clog2(MAX_ROWS + 1);
    localparam int VEC_AW  = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_VEC_WR = 2'd0,
        KIND_ROW_WR = 2'd1,
        KIND_MAC    = 2'd2,
        KIND_ROW_RD = 2'd3
    } kind_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_NUM_ROWS  = 1'b0,
        REG_NUM_SLOTS = 1'b1
    } cfg_reg_t;

    // controller to datapath
    typedef struct packed {
        logic vec_wr;
        logic row_wr;
        logic mac_rd;
        logic mac_mul;
        logic mac_wb;
        logic row_rd;
        logic row_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: src/esmv_entry_if.sv
// ----------------------------------------------------------------------------
// esmv_entry_if
// request channel into the unit: kind, index and operand values
// ----------------------------------------------------------------------------
interface esmv_entry_if import esmv_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  entry_value;
    logic signed [ACC_W-1:0]  row_init;

    modport source (output valid, kind, index, entry_value, row_init, input ready);
    modport sink   (input valid, kind, index, entry_value, row_init, output ready);

endinterface

// File: src/esmv_result_if.sv
// ----------------------------------------------------------------------------
// esmv_result_if
// result channel out of the unit: row value and status flags
// ----------------------------------------------------------------------------
interface esmv_result_if import esmv_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [ACC_W-1:0]  row_value;
    logic                     saturated;
    logic                     pass_complete;

    modport source (output valid, row_value, saturated, pass_complete, input ready);
    modport sink   (input valid, row_value, saturated, pass_complete, output ready);

endinterface

// File: src/esmv_ram.sv
// ----------------------------------------------------------------------------
// esmv_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module esmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/esmv_ctrl.sv
// ----------------------------------------------------------------------------
// esmv_ctrl
// sequencer: decodes each request and steps the datapath through it
// ----------------------------------------------------------------------------
module esmv_ctrl import esmv_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [KIND_W-1:0] in_kind,
    output logic              in_ready,
    input  dp_status_t        status,
    output dp_cmd_t           cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC_RD,
        ST_MAC_WB,
        ST_ROW_RD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(in_kind))
                        KIND_VEC_WR: cmd.vec_wr = 1'b1;
                        KIND_ROW_WR: cmd.row_wr = 1'b1;
                        KIND_MAC:
                        begin
                            cmd.mac_rd = 1'b1;
                            state_next = ST_MAC_RD;
                        end
                        KIND_ROW_RD:
                        begin
                            cmd.row_rd = 1'b1;
                            state_next = ST_ROW_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC_RD:
            begin
                cmd.mac_mul = 1'b1;
                state_next  = ST_MAC_WB;
            end
            ST_MAC_WB:
            begin
                cmd.mac_wb = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ROW_RD:
            begin
                if (status.out_free)
                begin
                    cmd.row_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/esmv_dp.sv
// ----------------------------------------------------------------------------
// esmv_dp
// datapath: vector and result rams, multiply, saturating add, counters
// ----------------------------------------------------------------------------
module esmv_dp import esmv_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     cfg_we,
    input  logic [CFG_IW-1:0]        cfg_index,
    input  logic [CFG_DW-1:0]        cfg_data,
    input  logic [IDX_W-1:0]         index,
    input  logic signed [VAL_W-1:0]  entry_value,
    input  logic signed [ACC_W-1:0]  row_init,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ACC_W-1:0]  row_value,
    output logic                     saturated,
    output logic                     pass_complete
);

    // configuration, held already clamped
    logic [ROW_CW-1:0]  rows_lim_reg;
    logic [SLOT_CW-1:0] slots_lim_reg;
    logic [NUM_ROWS_W-1:0]  raw_rows;
    logic [NUM_SLOTS_W-1:0] raw_slots;
    logic [ROW_CW-1:0]  rows_clamped;
    logic [SLOT_CW-1:0] slots_clamped;
    logic               cfg_hit;

    logic [ROW_AW-1:0]  row_cnt_reg;
    logic [ROW_AW-1:0]  row_cnt_next;
    logic [SLOT_AW-1:0] slot_cnt_reg;
    logic [SLOT_AW-1:0] slot_cnt_next;
    logic [ROW_CW-1:0]  row_inc;
    logic [SLOT_CW-1:0] slot_inc;
    logic               sat_reg;

    logic signed [VAL_W-1:0] val_reg;
    logic                    col_ok_reg;
    logic                    row_ok_reg;
    logic signed [ACC_W-1:0] prod_reg;

    logic                    out_valid_reg;
    logic signed [ACC_W-1:0] row_value_reg;
    logic                    saturated_reg;
    logic                    pass_reg;

    logic                    col_ok;
    logic                    row_ok;
    logic [VAL_W-1:0]        vec_rdata;
    logic signed [VAL_W-1:0] vec_op;
    logic [ACC_W-1:0]        res_rdata;
    logic                    res_we;
    logic [ROW_AW-1:0]       res_waddr;
    logic [ACC_W-1:0]        res_wdata;
    logic [ROW_AW-1:0]       res_raddr;
    logic [ACC_W-1:0]        sum;
    logic                    ovf;
    logic [ACC_W-1:0]        sat_sum;

    assign col_ok = ({{(32-IDX_W){1'b0}}, index} < VECTOR_DEPTH);
    assign row_ok = ({{(32-IDX_W){1'b0}}, index} < MAX_ROWS);

    esmv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .clk   (clk),
        .we    (cmd.vec_wr && col_ok),
        .waddr (VEC_AW'(index)),
        .wdata (entry_value),
        .re    (cmd.mac_rd),
        .raddr (VEC_AW'(index)),
        .rdata (vec_rdata)
    );

    assign res_we    = (cmd.row_wr && row_ok) || cmd.mac_wb;
    assign res_waddr = cmd.mac_wb ? row_cnt_reg : ROW_AW'(index);
    assign res_wdata = cmd.mac_wb ? sat_sum : row_init;
    assign res_raddr = cmd.mac_rd ? row_cnt_reg : ROW_AW'(index);

    esmv_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_ROWS)
    ) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .re    (cmd.mac_rd || cmd.row_rd),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    // saturating accumulate
    assign vec_op  = col_ok_reg ? $signed(vec_rdata) : '0;
    assign sum     = res_rdata + prod_reg;
    assign ovf     = (res_rdata[ACC_W-1] == prod_reg[ACC_W-1]) &&
                     (sum[ACC_W-1] != res_rdata[ACC_W-1]);
    assign sat_sum = ovf ? (res_rdata[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                               : {1'b0, {(ACC_W-1){1'b1}}})
                         : sum;

    // register clamping
    assign raw_rows      = cfg_data[NUM_ROWS_W-1:0];
    assign raw_slots     = cfg_data[NUM_SLOTS_W-1:0];
    assign rows_clamped  = (raw_rows == '0) ? ROW_CW'(1) :
                           ({{(32-NUM_ROWS_W){1'b0}}, raw_rows} > MAX_ROWS) ?
                           ROW_CW'(MAX_ROWS) : ROW_CW'(raw_rows);
    assign slots_clamped = (raw_slots == '0) ? SLOT_CW'(1) :
                           ({{(32-NUM_SLOTS_W){1'b0}}, raw_slots} > MAX_SLOTS) ?
                           SLOT_CW'(MAX_SLOTS) : SLOT_CW'(raw_slots);
    assign cfg_hit = cfg_we && ((cfg_index == REG_NUM_ROWS) || (cfg_index == REG_NUM_SLOTS));

    // slot-major walk
    assign row_inc  = ROW_CW'(row_cnt_reg) + ROW_CW'(1);
    assign slot_inc = SLOT_CW'(slot_cnt_reg) + SLOT_CW'(1);

    always_comb
    begin
        row_cnt_next  = row_cnt_reg;
        slot_cnt_next = slot_cnt_reg;
        if (cfg_hit)
        begin
            row_cnt_next  = '0;
            slot_cnt_next = '0;
        end
        else if (cmd.mac_wb)
        begin
            if (row_inc >= rows_lim_reg)
            begin
                row_cnt_next  = '0;
                slot_cnt_next = (slot_inc >= slots_lim_reg) ? '0 : SLOT_AW'(slot_inc);
            end
            else
            begin
                row_cnt_next = ROW_AW'(row_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_lim_reg  <= ROW_CW'(1);
            slots_lim_reg <= SLOT_CW'(1);
            row_cnt_reg   <= '0;
            slot_cnt_reg  <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_NUM_ROWS))
            begin
                rows_lim_reg <= rows_clamped;
            end
            if (cfg_we && (cfg_index == REG_NUM_SLOTS))
            begin
                slots_lim_reg <= slots_clamped;
            end
            row_cnt_reg  <= row_cnt_next;
            slot_cnt_reg <= slot_cnt_next;
            if (cmd.mac_wb && ovf)
            begin
                sat_reg <= 1'b1;
            end
            if (cmd.row_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_rd)
        begin
            val_reg    <= entry_value;
            col_ok_reg <= col_ok;
        end
        if (cmd.row_rd)
        begin
            row_ok_reg <= row_ok;
        end
        if (cmd.mac_mul)
        begin
            // sign-extended 32x32 product, exact as a signed 64-bit integer
            prod_reg <= ACC_W'(val_reg) * ACC_W'(vec_op);
        end
        if (cmd.row_load)
        begin
            row_value_reg <= row_ok_reg ? $signed(res_rdata) : '0;
            saturated_reg <= sat_reg;
            pass_reg      <= (row_cnt_reg == '0) && (slot_cnt_reg == '0);
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign row_value       = row_value_reg;
    assign saturated       = saturated_reg;
    assign pass_complete   = pass_reg;

`ifndef ASSERT_OFF
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ROW_CW'(row_cnt_reg) < rows_lim_reg)
        else $error("row counter beyond row count");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        SLOT_CW'(slot_cnt_reg) < slots_lim_reg)
        else $error("slot counter beyond slot count");

    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sat_reg |=> sat_reg)
        else $error("saturation flag cleared without reset");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before delivery");
`endif

endmodule

// File: src/ellpack_sparse_matvec_unit.sv
// ----------------------------------------------------------------------------
// ellpack_sparse_matvec_unit
// one request at a time; vector and row writes complete on acceptance, and a
//   matrix entry occupies the unit through ram read, registered 32x32 multiply,
//   saturating add and write-back; a row read waits for a free output register
// reset: counters and sticky flag clear at once, both counts return to 1;
//   ram contents are undefined until written and need no clearing pass
// ----------------------------------------------------------------------------
module ellpack_sparse_matvec_unit import esmv_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    esmv_entry_if.sink        entry,
    esmv_result_if.source     result
);

    // command and status bundles between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // the sequencer decodes the request kind and owns the input handshake
    esmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (entry.valid),
        .in_kind  (entry.kind),
        .in_ready (entry.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // the datapath holds both rams, the walk counters and the output register,
    // so a read result can wait there while further requests are taken
    esmv_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .index         (entry.index),
        .entry_value   (entry.entry_value),
        .row_init      (entry.row_init),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .row_value     (result.row_value),
        .saturated     (result.saturated),
        .pass_complete (result.pass_complete)
    );

endmodule
